// ===== hdl/pfde_pkg.sv =====
// shared types and constants for the page framebuffer draw engine
// command codes, sequencer states and the byte merge unit controls
// no dependencies
`default_nettype none

package pfde_pkg;

  // command codes of the input mode field
  localparam logic [2:0] MODE_CLEAR   = 3'd0;
  localparam logic [2:0] MODE_PLOT    = 3'd1;
  localparam logic [2:0] MODE_BLIT    = 3'd2;
  localparam logic [2:0] MODE_RD_PAGE = 3'd3;
  localparam logic [2:0] MODE_RD_ROW  = 3'd4;

  // plot color codes
  localparam logic [1:0] COLOR_CLEAR = 2'd0;
  localparam logic [1:0] COLOR_SET   = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    JOB_PLOT,
    JOB_BLIT,
    JOB_RD_PAGE,
    JOB_RD_ROW
  } job_t;

  typedef enum logic [2:0] {
    MOP_PASS,
    MOP_CLR,
    MOP_SET,
    MOP_TGL,
    MOP_BLIT_HI,
    MOP_BLIT_LO
  } merge_op_t;

  typedef struct packed {
    merge_op_t  op;
    logic [2:0] shift;
  } merge_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/pfde_merge.sv =====
// shared shift and mask unit: merges a byte or one pixel into a stored byte
// and picks one pixel out of it
// depends on pfde_pkg
`default_nettype none

module pfde_merge (
  input  var pfde_pkg::merge_ctl_t ctl,
  input  wire logic [7:0]          old_byte,
  input  wire logic [7:0]          pix,
  output logic      [7:0]          new_byte,
  output logic                     pick_bit
);
  import pfde_pkg::*;

  logic [7:0] bit_m;
  logic [7:0] low_keep;

  always_comb begin
    bit_m    = 8'b1 << ctl.shift;
    low_keep = bit_m - 8'd1;
    pick_bit = old_byte[ctl.shift];
    case (ctl.op)
      MOP_CLR:     new_byte = old_byte & ~bit_m;
      MOP_SET:     new_byte = old_byte | bit_m;
      MOP_TGL:     new_byte = old_byte ^ bit_m;
      MOP_BLIT_HI: new_byte = (old_byte & low_keep) | ((pix << ctl.shift) & ~low_keep);
      // lower page byte: the bits that ran off the bottom of the upper byte
      MOP_BLIT_LO: new_byte = (old_byte & ~low_keep) |
                              ((pix >> (4'd8 - {1'b0, ctl.shift})) & low_keep);
      default:     new_byte = old_byte;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/page_framebuffer_draw_engine_core.sv =====
// top level of the page framebuffer draw engine: sequencer, frame store, result register
// depends on pfde_pkg and pfde_merge
`default_nettype none

// Monochrome frame of COLUMNS x 8*PAGES pixels kept as PAGES pages of COLUMNS column
// bytes (bit n of a byte is row 8*page+n) in a single-port-per-direction memory with
// registered read. A transaction holds the block from its accept through its memory
// access states (a read and a modify state per byte read, a clear state per byte) to a
// done state, so the memory port sets the rate: plot and page read access one byte, a
// blit also the lower page byte if its shift is nonzero and that byte is in the store,
// a row read makes eight read/merge pairs and a clear writes every byte. Off-screen and
// spare-mode transactions touch no memory. The result is loaded as the block returns to
// idle and shows up together with in_ready. After reset the block runs a clearing pass
// over the whole store with in_ready low. A finished result sits in the output register
// while the next transaction is accepted; while that register is still full and
// out_ready is low, the next result waits and in_ready stays low.
module page_framebuffer_draw_engine_core #(
  parameter int COLUMNS = 64,
  parameter int PAGES   = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_mode,
  input  wire logic [7:0] in_x,
  input  wire logic [7:0] in_y,
  input  wire logic [1:0] in_color,
  input  wire logic [7:0] in_pixels,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_read_data,
  output logic            out_in_range
);
  import pfde_pkg::*;

  localparam int STORE_BYTES = COLUMNS * PAGES;
  localparam int ROWS        = 8 * PAGES;
  localparam int SW          = $clog2(STORE_BYTES);
  // wide enough for any page*COLUMNS+x plus one more page
  localparam int WIDE        = $clog2(COLUMNS * 33 + 256);

  // sequencer and working registers
  state_t          state_r, state_nxt;
  job_t            job_r, job_nxt;
  merge_op_t       op_r, op_nxt;
  logic [WIDE-1:0] addr_r, addr_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic [2:0]      k_r, k_nxt;
  logic [2:0]      shift_r, shift_nxt;
  logic [7:0]      pix_r, pix_nxt;
  logic [7:0]      data_r, data_nxt;
  logic            ok_r, ok_nxt;
  logic            clr_report_r, clr_report_nxt;

  // result register
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r, out_data_nxt;
  logic            out_ok_r, out_ok_nxt;

  // frame store
  logic [7:0]      mem [STORE_BYTES];
  logic [7:0]      mem_rdata_r;
  logic            mem_we;
  logic            mem_re;
  logic [SW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;

  // command decode
  logic            accept;
  logic            on_screen;
  logic            row_ok;
  logic [WIDE-1:0] page_base;
  logic [WIDE-1:0] addr_a;
  logic [WIDE-1:0] addr_row;
  logic            a_ok;
  logic [WIDE-1:0] addr_b;
  logic            b_ok;
  logic            clear_last;

  // merge unit
  merge_ctl_t      mctl;
  logic [7:0]      merged;
  logic            picked;

  assign accept     = in_valid && in_ready;
  assign on_screen  = ({1'b0, in_x} < 9'(COLUMNS)) && ({1'b0, in_y} < 9'(ROWS));
  assign row_ok     = ({1'b0, in_y} < 9'(ROWS)) && ({in_x, 3'b111} < 11'(COLUMNS));
  assign page_base  = WIDE'(in_y[7:3]) * WIDE'(COLUMNS);
  assign addr_a     = page_base + WIDE'(in_x);
  assign addr_row   = page_base + WIDE'({in_x, 3'b000});
  assign a_ok       = addr_a < WIDE'(STORE_BYTES);
  assign addr_b     = addr_r + WIDE'(COLUMNS);
  assign b_ok       = addr_b < WIDE'(STORE_BYTES);
  assign clear_last = cnt_r == SW'(STORE_BYTES - 1);

  // second blit pass works on the lower page byte
  always_comb begin
    mctl.shift = shift_r;
    if (job_r == JOB_BLIT && k_r[0]) begin
      mctl.op = MOP_BLIT_LO;
    end else begin
      mctl.op = op_r;
    end
  end

  pfde_merge u_merge (
    .ctl      (mctl),
    .old_byte (mem_rdata_r),
    .pix      (pix_r),
    .new_byte (merged),
    .pick_bit (picked)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clear_last) begin
          state_nxt = clr_report_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_CLEAR:   state_nxt = ST_CLEAR;
            MODE_PLOT:    state_nxt = on_screen ? ST_READ : ST_DONE;
            MODE_BLIT:    state_nxt = a_ok ? ST_READ : ST_DONE;
            MODE_RD_PAGE: state_nxt = on_screen ? ST_READ : ST_DONE;
            MODE_RD_ROW:  state_nxt = row_ok ? ST_READ : ST_DONE;
            default:      state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_MODIFY;
      ST_MODIFY: begin
        case (job_r)
          JOB_BLIT: begin
            if (!k_r[0] && shift_r != 3'd0 && b_ok) begin
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          JOB_RD_ROW: state_nxt = (k_r == 3'd7) ? ST_DONE : ST_READ;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    job_nxt        = job_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    shift_nxt      = shift_r;
    pix_nxt        = pix_r;
    data_nxt       = data_r;
    ok_nxt         = ok_r;
    clr_report_nxt = clr_report_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_ok_nxt     = out_ok_r;
    in_ready       = state_r == ST_IDLE;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = addr_r[SW-1:0];
    mem_wdata      = merged;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = 8'h00;
        cnt_nxt   = cnt_r + SW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          shift_nxt      = in_y[2:0];
          pix_nxt        = (in_color != COLOR_CLEAR) ? ~in_pixels : in_pixels;
          data_nxt       = 8'h00;
          k_nxt          = 3'd0;
          cnt_nxt        = '0;
          addr_nxt       = addr_a;
          clr_report_nxt = 1'b0;
          ok_nxt         = 1'b0;
          op_nxt         = MOP_PASS;
          case (in_mode)
            MODE_CLEAR: begin
              clr_report_nxt = 1'b1;
              ok_nxt         = 1'b1;
            end
            MODE_PLOT: begin
              job_nxt = JOB_PLOT;
              ok_nxt  = on_screen;
              if (in_color == COLOR_CLEAR) begin
                op_nxt = MOP_CLR;
              end else if (in_color == COLOR_SET) begin
                op_nxt = MOP_SET;
              end else begin
                op_nxt = MOP_TGL;
              end
            end
            MODE_BLIT: begin
              job_nxt = JOB_BLIT;
              op_nxt  = MOP_BLIT_HI;
              ok_nxt  = a_ok;
            end
            MODE_RD_PAGE: begin
              job_nxt = JOB_RD_PAGE;
              ok_nxt  = on_screen;
            end
            MODE_RD_ROW: begin
              job_nxt  = JOB_RD_ROW;
              addr_nxt = addr_row;
              ok_nxt   = row_ok;
            end
            default: ok_nxt = 1'b0;
          endcase
        end
      end
      ST_READ: mem_re = 1'b1;
      ST_MODIFY: begin
        case (job_r)
          JOB_PLOT: mem_we = 1'b1;
          JOB_BLIT: begin
            mem_we   = 1'b1;
            k_nxt    = 3'd1;
            addr_nxt = addr_b;
          end
          JOB_RD_PAGE: data_nxt = mem_rdata_r;
          JOB_RD_ROW: begin
            // pixel at column base+k lands in bit 7-k
            data_nxt[3'd7 - k_r] = picked;
            k_nxt    = k_r + 3'd1;
            addr_nxt = addr_r + WIDE'(1);
          end
          default: data_nxt = data_r;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_ok_nxt    = ok_r;
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
      k_r          <= 3'd0;
      job_r        <= JOB_PLOT;
      op_r         <= MOP_PASS;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
      k_r          <= k_nxt;
      job_r        <= job_nxt;
      op_r         <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    shift_r    <= shift_nxt;
    pix_r      <= pix_nxt;
    data_r     <= data_nxt;
    ok_r       <= ok_nxt;
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  // frame store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[addr_r[SW-1:0]];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_in_range  = out_ok_r;

`ifndef SYNTHESIS
  // the store is only written by the clearing sweep or a read-modify-write
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_MODIFY))
    else $error("frame store written outside clear or modify");

  // a transaction that missed the screen never carries data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_in_range || out_read_data == 8'h00))
    else $error("read data present on an off-screen result");

  // one transaction at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // a read is always followed by its merge step
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_MODIFY))
    else $error("read not followed by modify");

  // only blits and row reads use the pass counter
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MODIFY && k_r != 3'd0) |-> (job_r == JOB_BLIT || job_r == JOB_RD_ROW))
    else $error("pass counter moved for a single-byte job");
`endif

endmodule

`default_nettype wire

// ===== verif/pfde_draw_checker.sv =====
// checker for the page framebuffer draw engine: mirrors the frame store and scores every result
// depends on pfde_pkg for the command codes
module pfde_draw_checker #(
  parameter int COLUMNS = 64,
  parameter int PAGES   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic [7:0] in_x,
  input  logic [7:0] in_y,
  input  logic [1:0] in_color,
  input  logic [7:0] in_pixels,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_read_data,
  input  logic       out_in_range,
  output int         error_count,
  output int         pending_results,
  output int         checked_results
);
  import pfde_pkg::*;

  localparam int STORE_BYTES = COLUMNS * PAGES;
  localparam int ROWS        = 8 * PAGES;

  typedef struct packed {
    logic [7:0] read_data;
    logic       in_range;
  } draw_result_t;

  logic [7:0]   frame_image [STORE_BYTES];
  draw_result_t expected_results [$];

  initial begin
    error_count     = 0;
    pending_results = 0;
    checked_results = 0;
    foreach (frame_image[i]) frame_image[i] = 8'h00;
  end

  // applies one command to the mirrored store and returns its result
  task automatic apply_draw_cmd(input logic [2:0] mode, input logic [7:0] x, input logic [7:0] y,
                                input logic [1:0] color, input logic [7:0] pixels,
                                output draw_result_t res);
    int         col;
    int         row;
    int         addr;
    int         next_addr;
    logic [2:0] shift;
    logic [7:0] bit_mask;
    logic [7:0] blit_byte;
    logic [7:0] low_keep;
    logic [7:0] upper_part;
    logic [7:0] lower_part;
    col   = int'(x);
    row   = int'(y);
    shift = y[2:0];
    res   = '0;
    case (mode)
      MODE_CLEAR: begin
        foreach (frame_image[i]) frame_image[i] = 8'h00;
        res.in_range = 1'b1;
      end
      MODE_PLOT: begin
        if (col < COLUMNS && row < ROWS) begin
          addr     = (row >> 3) * COLUMNS + col;
          bit_mask = 8'h01 << shift;
          if (color == COLOR_SET) frame_image[addr] = frame_image[addr] | bit_mask;
          else if (color == COLOR_CLEAR) frame_image[addr] = frame_image[addr] & ~bit_mask;
          else frame_image[addr] = frame_image[addr] ^ bit_mask;
          res.in_range = 1'b1;
        end
      end
      MODE_BLIT: begin
        // column is not clipped, so it runs on into the next page
        addr      = (row >> 3) * COLUMNS + col;
        next_addr = addr + COLUMNS;
        blit_byte = (color != COLOR_CLEAR) ? ~pixels : pixels;
        if (shift == 3'd0) begin
          if (addr < STORE_BYTES) begin
            frame_image[addr] = blit_byte;
            res.in_range      = 1'b1;
          end
        end else begin
          low_keep   = (8'h01 << shift) - 8'h01;
          upper_part = blit_byte << shift;
          lower_part = blit_byte >> (8 - int'(shift));
          if (addr < STORE_BYTES) begin
            frame_image[addr] = (frame_image[addr] & low_keep) | (upper_part & ~low_keep);
            res.in_range      = 1'b1;
          end
          if (next_addr < STORE_BYTES)
            frame_image[next_addr] = (frame_image[next_addr] & ~low_keep) | (lower_part & low_keep);
        end
      end
      MODE_RD_PAGE: begin
        if (col < COLUMNS && row < ROWS) begin
          res.read_data = frame_image[(row >> 3) * COLUMNS + col];
          res.in_range  = 1'b1;
        end
      end
      MODE_RD_ROW: begin
        if (row < ROWS && col * 8 + 7 < COLUMNS) begin
          addr = (row >> 3) * COLUMNS + col * 8;
          for (int k = 0; k < 8; k++)
            res.read_data[7 - k] = frame_image[addr + k][shift];
          res.in_range = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    draw_result_t predicted;
    draw_result_t oldest;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        checked_results <= checked_results + 1;
        if (expected_results.size() == 0) begin
          $error("pfde_draw_checker: result with nothing expected (read_data %h in_range %b)",
                 out_read_data, out_in_range);
          error_count <= error_count + 1;
        end else begin
          oldest = expected_results.pop_front();
          if (out_read_data !== oldest.read_data || out_in_range !== oldest.in_range)
            error_count <= error_count + 1;
          if (out_read_data !== oldest.read_data)
            $error("pfde_draw_checker: read_data expected %h actual %h",
                   oldest.read_data, out_read_data);
          if (out_in_range !== oldest.in_range)
            $error("pfde_draw_checker: in_range expected %b actual %b",
                   oldest.in_range, out_in_range);
        end
      end
      if (in_valid && in_ready) begin
        apply_draw_cmd(in_mode, in_x, in_y, in_color, in_pixels, predicted);
        expected_results.push_back(predicted);
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// top of the draw engine testbench: clock, reset, command stimulus, result back-pressure, verdict
// depends on pfde_pkg, page_framebuffer_draw_engine_core and pfde_draw_checker
module tb_top;
  import pfde_pkg::*;

  localparam int COLUMNS        = 64;
  localparam int PAGES          = 16;
  localparam int RANDOM_CMDS    = 650;
  // a clear walks the whole store, so allow several of those with nothing moving
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 40;

  // codes the package leaves unnamed
  localparam logic [1:0] COLOR_TOGGLE     = 2'd2;
  localparam logic [1:0] COLOR_TOGGLE_ALT = 2'd3;
  localparam logic [1:0] BLIT_KEEP        = 2'd0;
  localparam logic [1:0] BLIT_INVERT      = 2'd1;
  localparam logic [2:0] MODE_SPARE_A     = 3'd5;
  localparam logic [2:0] MODE_SPARE_B     = 3'd6;
  localparam logic [2:0] MODE_SPARE_C     = 3'd7;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [2:0] in_mode   = 3'd0;
  logic [7:0] in_x      = 8'd0;
  logic [7:0] in_y      = 8'd0;
  logic [1:0] in_color  = 2'd0;
  logic [7:0] in_pixels = 8'd0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_read_data;
  logic       out_in_range;

  int error_count;
  int pending_results;
  int checked_results;

  // sender burst state
  int burst_left   = 0;
  bit gaps_enabled = 1'b1;
  // per-command tallies for the summary
  int mode_tally [8];
  int stall_cycles;

  // receiver back-pressure style and how long it lasts
  logic [1:0] ready_style     = 2'd0;
  int         ready_phase_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  page_framebuffer_draw_engine_core #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_color     (in_color),
    .in_pixels    (in_pixels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data),
    .out_in_range (out_in_range)
  );

  pfde_draw_checker #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_color       (in_color),
    .in_pixels      (in_pixels),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_in_range   (out_in_range),
    .error_count    (error_count),
    .pending_results(pending_results),
    .checked_results(checked_results)
  );

  // receiver: switches between always ready, random stalls and periodic stall windows
  always @(posedge clk) begin
    if (ready_phase_cnt == 0) begin
      ready_style     <= 2'($urandom_range(0, 2));
      ready_phase_cnt <= $urandom_range(50, 300);
    end else begin
      ready_phase_cnt <= ready_phase_cnt - 1;
    end
    case (ready_style)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (ready_phase_cnt % 16) >= 11;
    endcase
  end

  // watchdog: ends the run if no transaction moves on either channel for too long
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("tb_top: timeout, %0d cycles with no transaction", WATCHDOG_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  // one command transaction; valid stays up through a burst, drops for a random gap after it when gaps are enabled
  task automatic send_draw_cmd(input logic [2:0] mode, input logic [7:0] x, input logic [7:0] y,
                               input logic [1:0] color, input logic [7:0] pixels);
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_x      <= x;
    in_y      <= y;
    in_color  <= color;
    in_pixels <= pixels;
    do @(posedge clk); while (!in_ready);
    mode_tally[mode]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (gaps_enabled) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // holds the sender until every outstanding result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    logic [2:0] mode;
    logic [7:0] x;
    logic [7:0] y;
    int         pick;

    foreach (mode_tally[i]) mode_tally[i] = 0;
    // single synchronous reset; the block then runs its own clearing pass
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fresh store, plot corners, off-screen points, toggles and page reads
    send_draw_cmd(MODE_RD_PAGE, 8'd0, 8'd0, BLIT_KEEP, 8'h00);
    send_draw_cmd(MODE_PLOT, 8'd0, 8'd0, COLOR_SET, 8'h00);
    send_draw_cmd(MODE_PLOT, 8'd63, 8'd127, COLOR_SET, 8'hff);
    send_draw_cmd(MODE_PLOT, 8'd64, 8'd0, COLOR_SET, 8'h00);
    send_draw_cmd(MODE_PLOT, 8'd0, 8'd128, COLOR_SET, 8'h00);
    send_draw_cmd(MODE_PLOT, 8'd255, 8'd255, COLOR_TOGGLE, 8'h00);
    send_draw_cmd(MODE_PLOT, 8'd63, 8'd127, COLOR_CLEAR, 8'h00);
    send_draw_cmd(MODE_PLOT, 8'd10, 8'd20, COLOR_TOGGLE, 8'h00);
    send_draw_cmd(MODE_PLOT, 8'd10, 8'd21, COLOR_TOGGLE_ALT, 8'h00);
    send_draw_cmd(MODE_RD_PAGE, 8'd10, 8'd16, BLIT_KEEP, 8'h00);
    send_draw_cmd(MODE_RD_PAGE, 8'd64, 8'd0, BLIT_KEEP, 8'h00);
    send_draw_cmd(MODE_RD_PAGE, 8'd0, 8'd128, BLIT_KEEP, 8'h00);
    // directed: aligned and shifted blits, run-on column, writes past the end of the store
    send_draw_cmd(MODE_BLIT, 8'd5, 8'd16, BLIT_KEEP, 8'ha5);
    send_draw_cmd(MODE_BLIT, 8'd5, 8'd19, BLIT_INVERT, 8'h0f);
    send_draw_cmd(MODE_BLIT, 8'd0, 8'd119, BLIT_KEEP, 8'h81);
    send_draw_cmd(MODE_BLIT, 8'd63, 8'd127, BLIT_KEEP, 8'hff);
    send_draw_cmd(MODE_BLIT, 8'd255, 8'd0, COLOR_TOGGLE_ALT, 8'h3c);
    send_draw_cmd(MODE_BLIT, 8'd200, 8'd121, BLIT_KEEP, 8'hff);
    send_draw_cmd(MODE_BLIT, 8'd255, 8'd255, BLIT_INVERT, 8'h00);
    // directed: row reads in and out of range, spare modes, clear then read back
    send_draw_cmd(MODE_RD_ROW, 8'd0, 8'd16, BLIT_KEEP, 8'h00);
    send_draw_cmd(MODE_RD_ROW, 8'd7, 8'd127, BLIT_KEEP, 8'h00);
    send_draw_cmd(MODE_RD_ROW, 8'd8, 8'd0, BLIT_KEEP, 8'h00);
    send_draw_cmd(MODE_RD_ROW, 8'd0, 8'd128, BLIT_KEEP, 8'h00);
    send_draw_cmd(MODE_SPARE_A, 8'd1, 8'd1, COLOR_SET, 8'h55);
    send_draw_cmd(MODE_SPARE_B, 8'd0, 8'd0, BLIT_KEEP, 8'h00);
    send_draw_cmd(MODE_SPARE_C, 8'hff, 8'hff, COLOR_TOGGLE_ALT, 8'hff);
    send_draw_cmd(MODE_CLEAR, 8'd0, 8'd0, BLIT_KEEP, 8'h00);
    send_draw_cmd(MODE_RD_PAGE, 8'd5, 8'd16, BLIT_KEEP, 8'h00);

    // random: mostly on-screen draws and reads, a lot of them in a small window so reads
    // land on pixels that were just drawn; some off-screen and spare-mode noise
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      // pressure: sender holds off until everything is back
      if (n == 300) wait_for_drain();
      // stretch with no sender gaps
      gaps_enabled = !(n >= 400 && n < 480);

      pick = $urandom_range(0, 99);
      if (pick < 2) mode = MODE_CLEAR;
      else if (pick < 31) mode = MODE_PLOT;
      else if (pick < 61) mode = MODE_BLIT;
      else if (pick < 78) mode = MODE_RD_PAGE;
      else if (pick < 95) mode = MODE_RD_ROW;
      else mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));

      pick = $urandom_range(0, 9);
      if (mode == MODE_RD_ROW) x = (pick < 9) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      else if (pick < 4) x = 8'($urandom_range(0, 15));
      else if (pick < 9) x = 8'($urandom_range(0, COLUMNS - 1));
      else x = 8'($urandom_range(0, 255));

      pick = $urandom_range(0, 9);
      if (pick < 4) y = 8'($urandom_range(0, 31));
      else if (pick < 9) y = 8'($urandom_range(0, 8 * PAGES - 1));
      else y = 8'($urandom_range(0, 255));

      send_draw_cmd(mode, x, y, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end

    // drain, then give the block time to show any stray result
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d clears, %0d plots, %0d blits, %0d page reads, %0d row reads, %0d spare",
             mode_tally[MODE_CLEAR], mode_tally[MODE_PLOT], mode_tally[MODE_BLIT],
             mode_tally[MODE_RD_PAGE], mode_tally[MODE_RD_ROW],
             mode_tally[MODE_SPARE_A] + mode_tally[MODE_SPARE_B] + mode_tally[MODE_SPARE_C]);
    $display("tb_top: %0d results scored against the mirrored frame store, %0d mismatches",
             checked_results, error_count);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pfde_pkg.sv
hdl/pfde_merge.sv
hdl/page_framebuffer_draw_engine_core.sv
verif/pfde_draw_checker.sv
verif/tb_top.sv
